// ===== rtl/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg
// Types, token codes, command/status bundles and lookup functions shared by
// the source text lexer modules.
// ----------------------------------------------------------------------------
package stl_pkg;

   localparam int MAX_SYMBOLS_DEF    = 64;
   localparam int MAX_NAME_CHARS_DEF = 16;
   localparam int LEN_SAT            = 4095;
   localparam int COL_SAT            = 4095;
   localparam int KW_COUNT           = 35;
   localparam int KW_CHARS           = 9;

   typedef logic signed [6:0] tok_code_type;
   typedef logic [2:0]        err_code_type;

   localparam tok_code_type TK_INVALID = -7'sd1;
   localparam tok_code_type TK_END     = 7'sd0;
   localparam tok_code_type TK_ID      = 7'sd36;
   localparam tok_code_type TK_NUMBER  = 7'sd37;
   localparam tok_code_type TK_STRING  = 7'sd38;
   localparam tok_code_type TK_LPAREN  = 7'sd39;
   localparam tok_code_type TK_RPAREN  = 7'sd40;
   localparam tok_code_type TK_STAR    = 7'sd41;
   localparam tok_code_type TK_REMARK  = 7'sd42;
   localparam tok_code_type TK_PLUS    = 7'sd43;
   localparam tok_code_type TK_COMMA   = 7'sd44;
   localparam tok_code_type TK_MINUS   = 7'sd45;
   localparam tok_code_type TK_PERIOD  = 7'sd46;
   localparam tok_code_type TK_RANGE   = 7'sd47;
   localparam tok_code_type TK_SLASH   = 7'sd48;
   localparam tok_code_type TK_COLON   = 7'sd50;
   localparam tok_code_type TK_ASSIGN  = 7'sd51;
   localparam tok_code_type TK_SEMI    = 7'sd52;
   localparam tok_code_type TK_LT      = 7'sd53;
   localparam tok_code_type TK_LE      = 7'sd54;
   localparam tok_code_type TK_NE      = 7'sd55;
   localparam tok_code_type TK_EQ      = 7'sd56;
   localparam tok_code_type TK_GT      = 7'sd57;
   localparam tok_code_type TK_GE      = 7'sd58;
   localparam tok_code_type TK_LBRACK  = 7'sd59;
   localparam tok_code_type TK_RBRACK  = 7'sd60;

   localparam err_code_type ERR_NONE      = 3'd0;
   localparam err_code_type ERR_CHAR      = 3'd1;
   localparam err_code_type ERR_QUOTE     = 3'd2;
   localparam err_code_type ERR_REM_OPEN  = 3'd3;
   localparam err_code_type ERR_REM_SLASH = 3'd4;
   localparam err_code_type ERR_NUMBER    = 3'd5;

   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_SPACE = 8'd32;

   typedef enum logic [3:0] {
      LX_START, LX_COLON, LX_NUMBER, LX_WORD, LX_STRING, LX_SLASH,
      LX_REMARK, LX_REMARK_STAR, LX_GREATER, LX_LESS, LX_PERIOD
   } lex_state_type;

   typedef enum logic [2:0] {
      C_IDLE, C_PASS, C_KWD, C_RD, C_CMP, C_MISS, C_FIN, C_DONE
   } ctl_state_type;

   typedef struct packed {
      logic load_char;
      logic pass_en;
      logic kw_en;
      logic idx_clr;
      logic idx_inc;
      logic rd_en;
      logic sym_hit;
      logic sym_new;
      logic sym_full;
      logic fin_en;
      logic held_load;
      logic held_clr;
      logic push_out;
      logic push_last;
   } stl_cmd_type;

   typedef struct packed {
      logic done;
      logic again_now;
      logic again;
      logic sym_type;
      logic count_zero;
      logic hit;
      logic idx_last;
      logic room;
      logic emit;
      logic held_valid;
      logic out_free;
   } stl_stat_type;

   localparam logic [8*KW_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
      72'("and"), 72'("array"), 72'("begin"), 72'("bool"), 72'("call"),
      72'("case"), 72'("char"), 72'("constant"), 72'("dim"), 72'("do"),
      72'("else"), 72'("end"), 72'("false"), 72'("for"), 72'("if"),
      72'("input"), 72'("integer"), 72'("not"), 72'("of"), 72'("or"),
      72'("output"), 72'("procedure"), 72'("program"), 72'("read"),
      72'("real"), 72'("repeat"), 72'("set"), 72'("stop"), 72'("then"),
      72'("to"), 72'("true"), 72'("until"), 72'("var"), 72'("while"),
      72'("write")
   };

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd3, 4'd5, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4, 4'd8, 4'd3, 4'd2,
      4'd4, 4'd3, 4'd5, 4'd3, 4'd2, 4'd5, 4'd7, 4'd3, 4'd2, 4'd2,
      4'd6, 4'd9, 4'd7, 4'd4, 4'd4, 4'd6, 4'd3, 4'd4, 4'd4, 4'd2,
      4'd4, 4'd5, 4'd3, 4'd5, 4'd5
   };

   function automatic tok_code_type single_code(input logic [7:0] c);
      tok_code_type code;
      case (c)
         8'h28:   code = TK_LPAREN;
         8'h29:   code = TK_RPAREN;
         8'h2A:   code = TK_STAR;
         8'h2B:   code = TK_PLUS;
         8'h2C:   code = TK_COMMA;
         8'h2D:   code = TK_MINUS;
         8'h3B:   code = TK_SEMI;
         8'h3D:   code = TK_EQ;
         8'h5B:   code = TK_LBRACK;
         8'h5D:   code = TK_RBRACK;
         default: code = TK_INVALID;
      endcase
      return code;
   endfunction

   // t holds the first text byte in its low byte
   function automatic tok_code_type word_code(input logic [8*KW_CHARS-1:0] t,
                                              input logic [11:0] n);
      logic [8*KW_CHARS-1:0] cand;
      tok_code_type          code;
      cand = '0;
      code = TK_ID;
      if (n <= 12'(KW_CHARS)) begin
         for (int i = 0; i < KW_CHARS; i++) begin
            if (12'(i) < n) cand[8*(int'(n)-1-i) +: 8] = t[8*i +: 8];
         end
         for (int k = 0; k < KW_COUNT; k++) begin
            if (12'(KW_LEN[k]) == n && cand == KW_TEXT[k]) code = 7'(k + 1);
         end
      end
      return code;
   endfunction

endpackage

// ===== rtl/stl_ctrl.sv =====
// ----------------------------------------------------------------------------
// stl_ctrl
// Sequencer: runs up to two passes per character, keyword lookup, symbol
// table search and result hand-off.
// ----------------------------------------------------------------------------
module stl_ctrl
   import stl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  stl_stat_type stat,
   output stl_cmd_type  cmd
);

   ctl_state_type state_ff, state_in;
   logic          pass_ff, pass_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pass_in   = pass_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         C_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_char = 1'b1;
               pass_in       = 1'b0;
               state_in      = C_PASS;
            end
         end
         C_PASS: begin
            cmd.pass_en = 1'b1;
            if (stat.done) begin
               state_in = C_KWD;
            end else if (stat.again_now && !pass_ff) begin
               pass_in = 1'b1;
            end else begin
               state_in = C_DONE;
            end
         end
         C_KWD: begin
            cmd.kw_en = 1'b1;
            if (!stat.sym_type) begin
               state_in = C_FIN;
            end else if (stat.count_zero) begin
               state_in = C_MISS;
            end else begin
               cmd.idx_clr = 1'b1;
               state_in    = C_RD;
            end
         end
         C_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = C_CMP;
         end
         C_CMP: begin
            if (stat.hit) begin
               cmd.sym_hit = 1'b1;
               state_in    = C_FIN;
            end else if (stat.idx_last) begin
               state_in = C_MISS;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = C_RD;
            end
         end
         C_MISS: begin
            if (stat.room) cmd.sym_new = 1'b1;
            else           cmd.sym_full = 1'b1;
            state_in = C_FIN;
         end
         C_FIN: begin
            if (!stat.emit || !stat.held_valid || stat.out_free) begin
               cmd.fin_en = 1'b1;
               if (stat.emit) begin
                  cmd.held_load = 1'b1;
                  cmd.push_out  = stat.held_valid;
               end
               if (stat.again && !pass_ff) begin
                  pass_in  = 1'b1;
                  state_in = C_PASS;
               end else begin
                  state_in = C_DONE;
               end
            end
         end
         C_DONE: begin
            if (!stat.held_valid) begin
               state_in = C_IDLE;
            end else if (stat.out_free) begin
               cmd.push_out  = 1'b1;
               cmd.push_last = 1'b1;
               cmd.held_clr  = 1'b1;
               state_in      = C_IDLE;
            end
         end
         default: state_in = C_IDLE;
      endcase
   end

endmodule

// ===== rtl/stl_dp.sv =====
// ----------------------------------------------------------------------------
// stl_dp
// Datapath: character pass logic, token text, position counters, symbol
// table memory, held result and output register.
// ----------------------------------------------------------------------------
module stl_dp
   import stl_pkg::*;
#(
   parameter int MAX_SYMBOLS    = MAX_SYMBOLS_DEF,
   parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  stl_cmd_type         cmd,
   output stl_stat_type        stat,
   input  logic [7:0]          req_char_code,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [6:0]   rsp_token_type,
   output logic [2:0]          rsp_error_kind,
   output logic [6:0]          rsp_symbol_number,
   output logic [15:0]         rsp_line_number,
   output logic signed [12:0]  rsp_column_number,
   output logic                rsp_name_truncated,
   output logic                rsp_table_full,
   output logic                rsp_end_of_input,
   output logic                rsp_last_of_run
);

   localparam int SW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
   localparam int CW = $clog2(MAX_SYMBOLS + 1);
   localparam int IW = $clog2(MAX_NAME_CHARS);
   localparam int LW = $clog2(MAX_NAME_CHARS + 1);
   localparam int NB = 8 * MAX_NAME_CHARS;

   logic [7:0]    char_ff;
   lex_state_type lex_ff;
   logic [7:0]    text_ff [MAX_NAME_CHARS];
   logic [11:0]   len_ff;
   logic [15:0]   line_ff;
   logic [11:0]   col_ff;
   logic          pend_ff;
   logic [CW-1:0] count_ff;
   logic [SW-1:0] idx_ff;
   tok_code_type  type_ff;
   err_code_type  err_ff;
   logic          remark_ff;
   logic          again_ff;
   logic [6:0]    sym_ff;
   logic          full_ff;

   logic [NB-1:0] name_mem [MAX_SYMBOLS];
   logic [LW-1:0] nlen_mem [MAX_SYMBOLS];
   logic [NB-1:0] rd_name_ff;
   logic [LW-1:0] rd_len_ff;

   // ---- one pass over the current character
   logic          repaired, back, keep, done, remark;
   logic [7:0]    ch;
   tok_code_type  p_type;
   err_code_type  p_err;
   lex_state_type lex_in;
   logic [15:0]   line_base;
   logic [11:0]   col_base;
   logic          is_dig, is_alp;

   always_comb begin
      line_base = line_ff;
      col_base  = col_ff;
      if (pend_ff) begin
         if (line_ff != 16'hFFFF) line_base = line_ff + 16'd1;
         col_base = '0;
      end
      repaired = (char_ff == CH_NUL) &&
                 (lex_ff == LX_STRING || lex_ff == LX_REMARK || lex_ff == LX_REMARK_STAR);
      ch       = repaired ? CH_LF : char_ff;
      is_dig   = ch inside {[8'h30:8'h39]};
      is_alp   = ch inside {[8'h61:8'h7A], [8'h41:8'h5A]};
      back     = 1'b0;
      keep     = 1'b1;
      done     = 1'b0;
      remark   = 1'b0;
      p_type   = TK_END;
      p_err    = ERR_NONE;
      lex_in   = lex_ff;
      case (lex_ff)
         LX_COLON: begin
            done = 1'b1;
            if (ch == 8'h3D) p_type = TK_ASSIGN;
            else begin p_type = TK_COLON; back = 1'b1; end
         end
         LX_GREATER: begin
            done = 1'b1;
            if (ch == 8'h3D) p_type = TK_GE;
            else begin p_type = TK_GT; back = 1'b1; end
         end
         LX_LESS: begin
            done = 1'b1;
            if (ch == 8'h3D)      p_type = TK_LE;
            else if (ch == 8'h3E) p_type = TK_NE;
            else begin p_type = TK_LT; back = 1'b1; end
         end
         LX_PERIOD: begin
            done = 1'b1;
            if (ch == 8'h2E) p_type = TK_RANGE;
            else begin p_type = TK_PERIOD; back = 1'b1; end
         end
         LX_STRING: begin
            if (ch == 8'h27) begin
               keep = 1'b0; done = 1'b1; p_type = TK_STRING;
            end else if (ch == CH_LF) begin
               done = 1'b1; p_type = TK_INVALID; p_err = ERR_QUOTE;
            end
         end
         LX_SLASH: begin
            if (ch == 8'h2A) lex_in = LX_REMARK;
            else begin done = 1'b1; back = 1'b1; p_type = TK_SLASH; end
         end
         LX_REMARK: begin
            if (ch == 8'h2A) lex_in = LX_REMARK_STAR;
            else if (ch == CH_LF) begin
               remark = 1'b1; done = 1'b1; p_type = TK_INVALID; p_err = ERR_REM_OPEN;
            end
         end
         LX_REMARK_STAR: begin
            remark = 1'b1;
            if (ch == 8'h2F) begin
               done = 1'b1; p_type = TK_REMARK;
            end else if (ch == CH_LF) begin
               done = 1'b1; p_type = TK_INVALID; p_err = ERR_REM_SLASH;
            end else begin
               lex_in = LX_REMARK;
            end
         end
         LX_NUMBER: begin
            if (!is_dig) begin
               back = 1'b1; done = 1'b1; p_type = TK_NUMBER;
               if (is_alp) p_err = ERR_NUMBER;
            end
         end
         LX_WORD: begin
            if (!is_dig && !is_alp) begin
               back = 1'b1; done = 1'b1; p_type = TK_ID;
            end
         end
         default: begin
            lex_in = LX_START;
            if (is_dig)              lex_in = LX_NUMBER;
            else if (is_alp)         lex_in = LX_WORD;
            else if (ch == 8'h3A)    lex_in = LX_COLON;
            else if (ch == 8'h27) begin
               keep = 1'b0; lex_in = LX_STRING;
            end
            else if (ch == 8'h2F)    lex_in = LX_SLASH;
            else if (ch == 8'h3E)    lex_in = LX_GREATER;
            else if (ch == 8'h3C)    lex_in = LX_LESS;
            else if (ch == 8'h2E)    lex_in = LX_PERIOD;
            else if (ch == CH_NUL) begin
               done = 1'b1; p_type = TK_END; keep = 1'b0;
            end
            else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_LF) keep = 1'b0;
            else begin
               done   = 1'b1;
               p_type = single_code(ch);
               if (p_type == TK_INVALID) p_err = ERR_CHAR;
            end
         end
      endcase
      if (back) keep = 1'b0;
   end

   // ---- keyword and symbol compare
   logic [8*KW_CHARS-1:0] kw_text;
   tok_code_type          final_type;
   logic [LW-1:0]         slen;
   logic                  hit;
   logic [NB-1:0]         text_flat;

   always_comb begin
      for (int i = 0; i < KW_CHARS; i++) kw_text[8*i +: 8] = text_ff[i];
      for (int i = 0; i < MAX_NAME_CHARS; i++) text_flat[8*i +: 8] = text_ff[i];
      final_type = (type_ff == TK_ID) ? word_code(kw_text, len_ff) : type_ff;
      slen       = (len_ff > 12'(MAX_NAME_CHARS)) ? LW'(MAX_NAME_CHARS) : len_ff[LW-1:0];
      hit        = (rd_len_ff == slen);
      for (int i = 0; i < MAX_NAME_CHARS; i++) begin
         if (LW'(i) < slen && rd_name_ff[8*i +: 8] != text_ff[i]) hit = 1'b0;
      end
   end

   // ---- result fields
   logic signed [13:0] col_raw;
   logic signed [12:0] col_res;
   logic [15:0]        line_res;

   always_comb begin
      col_raw  = $signed({2'b00, col_ff}) - $signed({2'b00, len_ff}) + 14'sd1;
      col_res  = (col_raw > 14'sd4095) ? 13'sd4095 : col_raw[12:0];
      line_res = (line_ff != 16'hFFFF) ? line_ff + 16'd1 : line_ff;
   end

   // ---- control and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         lex_ff   <= LX_START;
         len_ff   <= '0;
         line_ff  <= '0;
         col_ff   <= '0;
         pend_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         if (cmd.pass_en) begin
            line_ff <= line_base;
            col_ff  <= (!back && ch != CH_NUL && col_base < 12'(COL_SAT)) ?
                       col_base + 12'd1 : col_base;
            pend_ff <= !back && ch == CH_LF;
            lex_ff  <= done ? LX_START : lex_in;
            if (keep && len_ff < 12'(LEN_SAT)) len_ff <= len_ff + 12'd1;
         end
         if (cmd.fin_en) len_ff <= '0;
         if (cmd.sym_new) count_ff <= count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_char) char_ff <= req_char_code;
      if (cmd.pass_en) begin
         if (keep && len_ff < 12'(MAX_NAME_CHARS)) text_ff[len_ff[IW-1:0]] <= ch;
         type_ff   <= p_type;
         err_ff    <= p_err;
         remark_ff <= remark;
         again_ff  <= back || repaired;
      end
      if (cmd.kw_en) begin
         type_ff <= final_type;
         sym_ff  <= '0;
         full_ff <= 1'b0;
      end
      if (cmd.idx_clr) idx_ff <= '0;
      if (cmd.idx_inc) idx_ff <= idx_ff + SW'(1);
      if (cmd.sym_hit) sym_ff <= 7'(idx_ff) + 7'd1;
      if (cmd.sym_new) sym_ff <= 7'(count_ff) + 7'd1;
      if (cmd.sym_full) full_ff <= 1'b1;
   end

   // ---- symbol table
   always_ff @(posedge clock) begin
      if (cmd.sym_new) begin
         name_mem[count_ff[SW-1:0]] <= text_flat;
         nlen_mem[count_ff[SW-1:0]] <= slen;
      end
      if (cmd.rd_en) begin
         rd_name_ff <= name_mem[idx_ff];
         rd_len_ff  <= nlen_mem[idx_ff];
      end
   end

   // ---- held result and output register
   logic               held_valid_ff;
   logic signed [6:0]  h_type_ff;
   logic [2:0]         h_err_ff;
   logic [6:0]         h_sym_ff;
   logic [15:0]        h_line_ff;
   logic signed [12:0] h_col_ff;
   logic               h_trunc_ff, h_full_ff, h_eoi_ff;
   logic               out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.held_clr)  held_valid_ff <= 1'b0;
         if (cmd.held_load) held_valid_ff <= 1'b1;
         if (cmd.push_out)  out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.held_load) begin
         h_type_ff  <= type_ff;
         h_err_ff   <= err_ff;
         h_sym_ff   <= sym_ff;
         h_line_ff  <= line_res;
         h_col_ff   <= col_res;
         h_trunc_ff <= len_ff > 12'(MAX_NAME_CHARS);
         h_full_ff  <= full_ff;
         h_eoi_ff   <= type_ff == TK_END;
      end
      if (cmd.push_out) begin
         rsp_token_type     <= h_type_ff;
         rsp_error_kind     <= h_err_ff;
         rsp_symbol_number  <= h_sym_ff;
         rsp_line_number    <= h_line_ff;
         rsp_column_number  <= h_col_ff;
         rsp_name_truncated <= h_trunc_ff;
         rsp_table_full     <= h_full_ff;
         rsp_end_of_input   <= h_eoi_ff;
         rsp_last_of_run    <= cmd.push_last;
      end
   end

   assign rsp_valid = out_valid_ff;

   always_comb begin
      stat            = '0;
      stat.done       = done;
      stat.again_now  = back || repaired;
      stat.again      = again_ff;
      stat.sym_type   = final_type == TK_ID || final_type == TK_NUMBER ||
                        final_type == TK_STRING;
      stat.count_zero = count_ff == '0;
      stat.hit        = hit;
      stat.idx_last   = CW'(idx_ff) == count_ff - CW'(1);
      stat.room       = count_ff < CW'(MAX_SYMBOLS);
      stat.emit       = err_ff != ERR_NONE || !remark_ff;
      stat.held_valid = held_valid_ff;
      stat.out_free   = !out_valid_ff || rsp_ready;
   end

endmodule

// ===== rtl/source_text_lexer.sv =====
// ----------------------------------------------------------------------------
// source_text_lexer
// Character-at-a-time tokenizer with keyword replacement and a shared symbol
// table for identifiers, numbers and strings.
//
//   channel  direction  ports
//   req      in         req_valid, req_ready, req_char_code
//   rsp      out        rsp_valid, rsp_ready, rsp_<field> (9 fields)
//
// A character without a token end runs accept, pass and close steps.
// A token end adds a keyword lookup step and a finish step; ids, numbers
// and strings also search the symbol table with a read and a compare step
// per entry (one read port, registered data), plus a miss step if no match.
// A reprocessed character runs a second pass. Reset clears counters and the
// symbol count; table contents are not cleared. While the rsp register holds
// an unaccepted transfer, the sequencer waits before handing over the next.
// ----------------------------------------------------------------------------
module source_text_lexer
   import stl_pkg::*;
#(
   parameter int MAX_SYMBOLS    = MAX_SYMBOLS_DEF,
   parameter int MAX_NAME_CHARS = MAX_NAME_CHARS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [6:0]  rsp_token_type,
   output logic [2:0]         rsp_error_kind,
   output logic [6:0]         rsp_symbol_number,
   output logic [15:0]        rsp_line_number,
   output logic signed [12:0] rsp_column_number,
   output logic               rsp_name_truncated,
   output logic               rsp_table_full,
   output logic               rsp_end_of_input,
   output logic               rsp_last_of_run
);

   stl_cmd_type  cmd;
   stl_stat_type stat;

   stl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   stl_dp #(
      .MAX_SYMBOLS    (MAX_SYMBOLS),
      .MAX_NAME_CHARS (MAX_NAME_CHARS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_char_code      (req_char_code),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_token_type     (rsp_token_type),
      .rsp_error_kind     (rsp_error_kind),
      .rsp_symbol_number  (rsp_symbol_number),
      .rsp_line_number    (rsp_line_number),
      .rsp_column_number  (rsp_column_number),
      .rsp_name_truncated (rsp_name_truncated),
      .rsp_table_full     (rsp_table_full),
      .rsp_end_of_input   (rsp_end_of_input),
      .rsp_last_of_run    (rsp_last_of_run)
   );

endmodule

// ===== bench/source_text_lexer_tb.sv =====
// ----------------------------------------------------------------------------
// source_text_lexer_tb
// Streams characters into the lexer and checks every token result against a
// behavioral tokenizer kept in the bench (state, counters, symbol table).
// Directed text first, then random token streams under three idle patterns.
// ----------------------------------------------------------------------------
module source_text_lexer_tb;
   import stl_pkg::*;

   localparam int NAME_CHARS  = MAX_NAME_CHARS_DEF;
   localparam int SYM_SLOTS   = MAX_SYMBOLS_DEF;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      logic signed [6:0]  token_type;
      logic [2:0]         error_kind;
      logic [6:0]         symbol_number;
      logic [15:0]        line_number;
      logic signed [12:0] column_number;
      logic               name_truncated;
      logic               table_full;
      logic               end_of_input;
      logic               last_of_run;
   } token_rec_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_char_code;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [6:0]  rsp_token_type;
   logic [2:0]         rsp_error_kind;
   logic [6:0]         rsp_symbol_number;
   logic [15:0]        rsp_line_number;
   logic signed [12:0] rsp_column_number;
   logic               rsp_name_truncated;
   logic               rsp_table_full;
   logic               rsp_end_of_input;
   logic               rsp_last_of_run;

   source_text_lexer i_dut (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // bench copy of the tokenizer state
   lex_state_type lex_state;
   logic [7:0]    tok_text [NAME_CHARS];
   logic [11:0]   tok_len;
   logic [15:0]   line_cnt;
   logic [11:0]   col_cnt;
   logic          line_pend;
   logic [7:0]    sym_text [SYM_SLOTS][NAME_CHARS];
   logic [4:0]    sym_len [SYM_SLOTS];
   int            sym_cnt;

   token_rec_type pending_tokens[$];
   token_rec_type step_res [2];
   int            step_n;

   int  snd_idle, rcv_idle;
   int  chars_sent, tokens_seen, errors_seen;
   int  cycles = 0;
   bit  failed;

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic int keyword_of_text();
      bit same;
      if (tok_len > NAME_CHARS) return TK_ID;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (12'(KW_LEN[k]) == tok_len) begin
            same = 1;
            for (int i = 0; i < int'(tok_len); i++)
               if (KW_TEXT[k][8*(int'(tok_len)-1-i) +: 8] != tok_text[i]) same = 0;
            if (same) return k + 1;
         end
      end
      return TK_ID;
   endfunction

   function automatic int symbol_of_text(output bit full);
      int  n;
      bit  same;
      n = tok_len > NAME_CHARS ? NAME_CHARS : int'(tok_len);
      full = 0;
      for (int i = 0; i < sym_cnt; i++) begin
         if (int'(sym_len[i]) == n) begin
            same = 1;
            for (int j = 0; j < n; j++)
               if (sym_text[i][j] != tok_text[j]) same = 0;
            if (same) return i + 1;
         end
      end
      if (sym_cnt < SYM_SLOTS) begin
         for (int j = 0; j < n; j++) sym_text[sym_cnt][j] = tok_text[j];
         sym_len[sym_cnt] = 5'(n);
         sym_cnt++;
         return sym_cnt;
      end
      full = 1;
      return 0;
   endfunction

   function automatic void close_token(int typ, int err, bit remark);
      int            sym, col;
      bit            full;
      token_rec_type r;
      sym = 0;
      full = 0;
      if (typ == TK_ID) typ = keyword_of_text();
      if (typ >= TK_ID && typ <= TK_STRING) sym = symbol_of_text(full);
      if ((err != 0 || !remark) && step_n < 2) begin
         col = int'(col_cnt) - int'(tok_len) + 1;
         if (col > 4095) col = 4095;
         if (col < -4095) col = -4095;
         r.token_type     = 7'(typ);
         r.error_kind     = 3'(err);
         r.symbol_number  = 7'(sym);
         r.line_number    = line_cnt < 16'hFFFF ? line_cnt + 16'd1 : 16'hFFFF;
         r.column_number  = 13'(col);
         r.name_truncated = tok_len > NAME_CHARS;
         r.table_full     = full;
         r.end_of_input   = typ == TK_END;
         r.last_of_run    = 0;
         step_res[step_n] = r;
         step_n++;
      end
      tok_len = 0;
      lex_state = LX_START;
   endfunction

   function automatic bit lex_pass(logic [7:0] c);
      logic [7:0] ch;
      bit         repaired, back, keep, done, remark;
      int         typ, err;
      ch = c; repaired = 0; back = 0; keep = 1; done = 0; remark = 0;
      typ = TK_END; err = ERR_NONE;
      if (line_pend) begin
         if (line_cnt < 16'hFFFF) line_cnt++;
         col_cnt = 0;
         line_pend = 0;
      end
      if (c == CH_NUL && (lex_state == LX_STRING || lex_state == LX_REMARK ||
                          lex_state == LX_REMARK_STAR)) begin
         ch = CH_LF;
         repaired = 1;
      end
      case (lex_state)
         LX_COLON: begin
            done = 1;
            if (ch == "=") typ = TK_ASSIGN; else begin typ = TK_COLON; back = 1; end
         end
         LX_GREATER: begin
            done = 1;
            if (ch == "=") typ = TK_GE; else begin typ = TK_GT; back = 1; end
         end
         LX_LESS: begin
            done = 1;
            if (ch == "=") typ = TK_LE;
            else if (ch == ">") typ = TK_NE;
            else begin typ = TK_LT; back = 1; end
         end
         LX_PERIOD: begin
            done = 1;
            if (ch == ".") typ = TK_RANGE; else begin typ = TK_PERIOD; back = 1; end
         end
         LX_STRING: begin
            if (ch == "'") begin keep = 0; done = 1; typ = TK_STRING; end
            else if (ch == CH_LF) begin done = 1; typ = TK_INVALID; err = ERR_QUOTE; end
         end
         LX_SLASH: begin
            if (ch == "*") lex_state = LX_REMARK;
            else begin done = 1; back = 1; typ = TK_SLASH; end
         end
         LX_REMARK: begin
            if (ch == "*") lex_state = LX_REMARK_STAR;
            else if (ch == CH_LF) begin
               remark = 1; done = 1; typ = TK_INVALID; err = ERR_REM_OPEN;
            end
         end
         LX_REMARK_STAR: begin
            remark = 1;
            if (ch == "/") begin done = 1; typ = TK_REMARK; end
            else if (ch == CH_LF) begin done = 1; typ = TK_INVALID; err = ERR_REM_SLASH; end
            else lex_state = LX_REMARK;
         end
         LX_NUMBER: begin
            if (!is_digit(ch)) begin
               back = 1; done = 1; typ = TK_NUMBER;
               if (is_alpha(ch)) err = ERR_NUMBER;
            end
         end
         LX_WORD: begin
            if (!is_digit(ch) && !is_alpha(ch)) begin back = 1; done = 1; typ = TK_ID; end
         end
         default: begin
            lex_state = LX_START;
            if (is_digit(ch)) lex_state = LX_NUMBER;
            else if (is_alpha(ch)) lex_state = LX_WORD;
            else if (ch == ":") lex_state = LX_COLON;
            else if (ch == "'") begin keep = 0; lex_state = LX_STRING; end
            else if (ch == "/") lex_state = LX_SLASH;
            else if (ch == ">") lex_state = LX_GREATER;
            else if (ch == "<") lex_state = LX_LESS;
            else if (ch == ".") lex_state = LX_PERIOD;
            else if (ch == CH_NUL) begin done = 1; typ = TK_END; keep = 0; end
            else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_LF) keep = 0;
            else begin
               done = 1;
               typ = single_code(ch);
               if (typ < 0) err = ERR_CHAR;
            end
         end
      endcase
      if (back) keep = 0;
      if (!back && ch != CH_NUL && col_cnt < 12'(COL_SAT)) col_cnt++;
      if (keep) begin
         if (tok_len < NAME_CHARS) tok_text[tok_len] = ch;
         if (tok_len < 12'(LEN_SAT)) tok_len++;
      end
      if (!back && ch == CH_LF) line_pend = 1;
      if (done) close_token(typ, err, remark);
      return back || repaired;
   endfunction

   function automatic void lex_char(logic [7:0] c);
      step_n = 0;
      if (lex_pass(c)) void'(lex_pass(c));
      if (step_n > 0) step_res[step_n-1].last_of_run = 1;
      for (int i = 0; i < step_n; i++)
         pending_tokens.insert(pending_tokens.size(), step_res[i]);
   endfunction

   task automatic send_char(logic [7:0] c);
      while ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      do @(posedge clock); while (!req_ready);
      lex_char(c);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   always @(negedge clock) rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= rcv_idle);

   always @(posedge clock) begin
      token_rec_type e;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL source_text_lexer");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         tokens_seen <= tokens_seen + 1;
         if (rsp_error_kind != ERR_NONE) errors_seen <= errors_seen + 1;
         if (pending_tokens.size() == 0) begin
            $error("unexpected token transfer, type %0d", rsp_token_type);
            failed = 1;
         end else begin
            e = pending_tokens.pop_front();
            if (rsp_token_type !== e.token_type) begin
               $error("token_type exp %0d got %0d", e.token_type, rsp_token_type); failed = 1;
            end
            if (rsp_error_kind !== e.error_kind) begin
               $error("error_kind exp %0d got %0d", e.error_kind, rsp_error_kind); failed = 1;
            end
            if (rsp_symbol_number !== e.symbol_number) begin
               $error("symbol_number exp %0d got %0d", e.symbol_number, rsp_symbol_number);
               failed = 1;
            end
            if (rsp_line_number !== e.line_number) begin
               $error("line_number exp %0d got %0d", e.line_number, rsp_line_number); failed = 1;
            end
            if (rsp_column_number !== e.column_number) begin
               $error("column_number exp %0d got %0d", e.column_number, rsp_column_number);
               failed = 1;
            end
            if (rsp_name_truncated !== e.name_truncated) begin
               $error("name_truncated exp %0d got %0d", e.name_truncated, rsp_name_truncated);
               failed = 1;
            end
            if (rsp_table_full !== e.table_full) begin
               $error("table_full exp %0d got %0d", e.table_full, rsp_table_full); failed = 1;
            end
            if (rsp_end_of_input !== e.end_of_input) begin
               $error("end_of_input exp %0d got %0d", e.end_of_input, rsp_end_of_input);
               failed = 1;
            end
            if (rsp_last_of_run !== e.last_of_run) begin
               $error("last_of_run exp %0d got %0d", e.last_of_run, rsp_last_of_run); failed = 1;
            end
         end
      end
   end

   task automatic test_operators_and_words();
      send_text("program x1:=42;if a<=b then c<>d>=e..f.g:h<i>j\n");
      send_text("(+)*,-=[]/ ;\tAND and write\n");
   endtask

   task automatic test_strings_and_remarks();
      send_text("'hi' '' 'open\n/* ok */ /* x ** / */ /**/ /* unclosed\n/* star *\n");
   endtask

   task automatic test_error_cases();
      send_text("12ab abcdefghijklmnopqrstuv abcdefghijklmnopqXYZ ");
      send_char(8'd13);
      send_char(8'hFF);
      send_char(8'h80);
      send_text("'tail");
      send_char(CH_NUL);
      send_text("/* tail");
      send_char(CH_NUL);
      send_text("/* tail *");
      send_char(CH_NUL);
      send_text("x");
      send_char(CH_NUL);
   endtask

   task automatic send_random_token();
      int    len;
      string ops;
      ops = "()*+,-;=[]:<>./";
      case ($urandom_range(9))
         0, 1: begin
            len = $urandom_range(9) == 0 ? $urandom_range(17, 24) : $urandom_range(1, 5);
            send_char(8'("a" + $urandom_range(3)));
            for (int i = 1; i < len; i++)
               send_char(8'($urandom_range(2) == 0 ? "0" + $urandom_range(2)
                                                   : "a" + $urandom_range(25)));
         end
         2: begin
            len = $urandom_range(KW_COUNT - 1);
            for (int i = 0; i < int'(KW_LEN[len]); i++)
               send_char(KW_TEXT[len][8*(int'(KW_LEN[len])-1-i) +: 8]);
         end
         3: begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) send_char(8'("0" + $urandom_range(9)));
            if ($urandom_range(7) == 0) send_char(8'("A" + $urandom_range(25)));
         end
         4: begin
            send_char("'");
            len = $urandom_range(4);
            for (int i = 0; i < len; i++) send_char(8'("a" + $urandom_range(25)));
            if ($urandom_range(9) != 0) send_char("'"); else send_char(CH_LF);
         end
         5: begin
            send_text("/*");
            len = $urandom_range(4);
            for (int i = 0; i < len; i++) send_char($urandom_range(1) ? "*" : "q");
            if ($urandom_range(9) != 0) send_text("*/"); else send_char(CH_LF);
         end
         6, 7: begin
            send_char(ops[$urandom_range(ops.len() - 1)]);
            if ($urandom_range(1)) send_char(ops[$urandom_range(ops.len() - 1)]);
         end
         8: send_char(8'($urandom_range(255)));
         default: begin
            case ($urandom_range(3))
               0: send_char(CH_TAB);
               1: send_char(CH_LF);
               2: if ($urandom_range(9) == 0) send_char(CH_NUL);
               default: ;
            endcase
         end
      endcase
      if ($urandom_range(2) != 0) send_char(CH_SPACE);
   endtask

   task automatic test_random_text(int count, int s_idle, int r_idle);
      int stop_at;
      snd_idle = s_idle;
      rcv_idle = r_idle;
      stop_at  = chars_sent + count;
      while (chars_sent < stop_at) send_random_token();
   endtask

   initial begin
      lex_state = LX_START; tok_len = 0; line_cnt = 0; col_cnt = 0; line_pend = 0;
      sym_cnt = 0; chars_sent = 0; tokens_seen = 0; errors_seen = 0;
      failed = 0; snd_idle = 37; rcv_idle = 85;
      reset = 1'b1; req_valid = 1'b0; req_char_code = '0; rsp_ready = 1'b0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      test_operators_and_words();
      test_strings_and_remarks();
      test_error_cases();
      test_random_text(275, 37, 85);
      test_random_text(275, 85, 37);
      test_random_text(275, 0, 0);
      req_valid <= 1'b0;
      while (pending_tokens.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      $display("Sent %0d characters, checked %0d token transfers (%0d with errors)",
               chars_sent, tokens_seen, errors_seen);
      $display("Symbol table entries used: %0d of %0d", sym_cnt, SYM_SLOTS);
      if (!failed && pending_tokens.size() == 0) begin
         $display("PASS source_text_lexer");
      end else begin
         $display("FAIL source_text_lexer");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/stl_pkg.sv
rtl/stl_ctrl.sv
rtl/stl_dp.sv
rtl/source_text_lexer.sv
bench/source_text_lexer_tb.sv
